>>> sv/stl_pkg.sv
// stl_pkg: token kinds, scanner modes, token and push bundles, keyword table
// and character classes for the script token lexer.
// No dependencies; used by stl_scan, stl_tokq and script_token_lexer_top.
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  typedef enum logic [4:0] {
    K_END      = 5'd0,
    K_NUM      = 5'd1,
    K_STR      = 5'd2,
    K_IDENT    = 5'd3,
    K_LET      = 5'd4,
    K_PRINT    = 5'd5,
    K_IF       = 5'd6,
    K_REPEAT   = 5'd7,
    K_FUNCTION = 5'd8,
    K_KWEND    = 5'd9,
    K_PLUS     = 5'd10,
    K_MINUS    = 5'd11,
    K_STAR     = 5'd12,
    K_SLASH    = 5'd13,
    K_PCT      = 5'd14,
    K_LPAR     = 5'd15,
    K_RPAR     = 5'd16,
    K_COMMA    = 5'd17,
    K_ASSIGN   = 5'd18,
    K_EQ       = 5'd19,
    K_NEQ      = 5'd20,
    K_LT       = 5'd21,
    K_LE       = 5'd22,
    K_GT       = 5'd23,
    K_GE       = 5'd24,
    K_UNK      = 5'd25
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_NUM   = 3'd1,
    M_STR   = 3'd2,
    M_IDENT = 3'd3,
    M_EQ    = 3'd4,
    M_BANG  = 3'd5,
    M_LT    = 3'd6,
    M_GT    = 3'd7
  } mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [15:0] start;
    logic [6:0]  len;
    logic        last;
  } tok_t;

  // Up to two tokens handed from the scanner to the queue in one cycle.
  typedef struct packed {
    logic [1:0] cnt;
    tok_t       t0;
    tok_t       t1;
  } push_t;

  localparam int N_KW    = 6;
  localparam int Q_DEPTH = 8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  function automatic logic ch_decimal(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic ch_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h5F);
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] idx);
    logic [3:0] l;
    unique case (idx)
      3'd0:    l = 4'd3;
      3'd1:    l = 4'd5;
      3'd2:    l = 4'd2;
      3'd3:    l = 4'd6;
      3'd4:    l = 4'd8;
      3'd5:    l = 4'd3;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

  // Keyword text, first character in the top byte; zero past the end.
  function automatic logic [7:0] kw_char(input logic [2:0] idx, input logic [7:0] pos);
    logic [63:0] w;
    logic [7:0]  ch;
    unique case (idx)
      3'd0:    w = {"let", 40'd0};
      3'd1:    w = {"print", 24'd0};
      3'd2:    w = {"if", 48'd0};
      3'd3:    w = {"repeat", 16'd0};
      3'd4:    w = "function";
      3'd5:    w = {"end", 40'd0};
      default: w = 64'd0;
    endcase
    if (pos < 8'd8) begin
      ch = w[8 * (7 - int'(pos[2:0])) +: 8];
    end else begin
      ch = 8'd0;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/stl_scan.sv
// stl_scan: front end of the lexer. Classifies each accepted byte, keeps the
// scanning state and hands zero, one or two finished tokens to the queue.
// Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_scan #(
  parameter int MAX_TEXT_LEN = 127,
  parameter int MAX_DIGITS   = 31,
  parameter int MAX_SOURCE   = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    src_byte,
  output stl_pkg::push_t     push
);

  localparam int RUN_MAX = (MAX_TEXT_LEN > MAX_DIGITS) ? MAX_TEXT_LEN : MAX_DIGITS;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);
  localparam int POS_W   = $clog2(MAX_SOURCE);

  stl_pkg::mode_t   mode_r, mode_nxt;
  logic [RUN_W-1:0] run_r, run_nxt;
  logic [31:0]      acc_r, acc_nxt;
  logic [POS_W-1:0] start_r, start_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       kwc_r, kwc_nxt;

  logic [7:0]       c;
  logic [7:0]       run8;
  logic [POS_W:0]   pos_inc;
  logic [POS_W-1:0] pos_wrap;
  logic             c_dig, c_alp, c_ws, c_nul;
  logic [5:0]       kw_first, kw_step;

  // start-of-token decode
  stl_pkg::mode_t   st_mode;
  logic             st_emit;
  stl_pkg::kind_t   st_kind;

  // pending-token flush
  logic             fl_valid;
  stl_pkg::tok_t    fl_tok;
  stl_pkg::kind_t   id_kind;
  stl_pkg::kind_t   pair_kind;

  logic             cont, close_str, pair, restart;

  assign c        = src_byte;
  assign run8     = 8'(run_r);
  assign c_dig    = stl_pkg::ch_decimal(c);
  assign c_alp    = stl_pkg::ch_letter(c);
  assign c_ws     = (c == stl_pkg::CH_SPACE) || (c == stl_pkg::CH_TAB) ||
                    (c == stl_pkg::CH_CR);
  assign c_nul    = (c == stl_pkg::CH_NUL);
  assign pos_inc  = {1'b0, pos_r} + (POS_W+1)'(1);
  assign pos_wrap = (pos_inc >= (POS_W+1)'(MAX_SOURCE)) ? '0 : pos_inc[POS_W-1:0];

  always_comb begin
    for (int i = 0; i < stl_pkg::N_KW; i++) begin
      kw_first[i] = (stl_pkg::kw_char(3'(i), 8'd0) == c);
      kw_step[i]  = (run8 < 8'(stl_pkg::kw_len(3'(i)))) &&
                    (stl_pkg::kw_char(3'(i), run8) == c);
    end
  end

  always_comb begin
    st_mode = stl_pkg::M_IDLE;
    st_emit = 1'b0;
    st_kind = stl_pkg::K_UNK;
    priority if (c_ws) begin
      st_mode = stl_pkg::M_IDLE;
    end else if (c_dig) begin
      st_mode = stl_pkg::M_NUM;
    end else if (c == stl_pkg::CH_QUOTE) begin
      st_mode = stl_pkg::M_STR;
    end else if (c_alp) begin
      st_mode = stl_pkg::M_IDENT;
    end else begin
      priority case (c)
        stl_pkg::CH_EQ:    st_mode = stl_pkg::M_EQ;
        stl_pkg::CH_BANG:  st_mode = stl_pkg::M_BANG;
        stl_pkg::CH_LT:    st_mode = stl_pkg::M_LT;
        stl_pkg::CH_GT:    st_mode = stl_pkg::M_GT;
        stl_pkg::CH_PLUS:  begin st_emit = 1'b1; st_kind = stl_pkg::K_PLUS;  end
        stl_pkg::CH_MINUS: begin st_emit = 1'b1; st_kind = stl_pkg::K_MINUS; end
        stl_pkg::CH_STAR:  begin st_emit = 1'b1; st_kind = stl_pkg::K_STAR;  end
        stl_pkg::CH_SLASH: begin st_emit = 1'b1; st_kind = stl_pkg::K_SLASH; end
        stl_pkg::CH_PCT:   begin st_emit = 1'b1; st_kind = stl_pkg::K_PCT;   end
        stl_pkg::CH_LPAR:  begin st_emit = 1'b1; st_kind = stl_pkg::K_LPAR;  end
        stl_pkg::CH_RPAR:  begin st_emit = 1'b1; st_kind = stl_pkg::K_RPAR;  end
        stl_pkg::CH_COMMA: begin st_emit = 1'b1; st_kind = stl_pkg::K_COMMA; end
        default:           begin st_emit = 1'b1; st_kind = stl_pkg::K_UNK;   end
      endcase
    end
  end

  // Identifier kind: the lowest keyword still in the running whose length fits.
  always_comb begin
    id_kind = stl_pkg::K_IDENT;
    for (int i = stl_pkg::N_KW - 1; i >= 0; i--) begin
      if (kwc_r[i] && (run8 == 8'(stl_pkg::kw_len(3'(i))))) begin
        id_kind = stl_pkg::kind_t'(5'(stl_pkg::K_LET) + 5'(i));
      end
    end
  end

  always_comb begin
    fl_valid       = (mode_r != stl_pkg::M_IDLE);
    fl_tok         = '0;
    fl_tok.start   = 16'(start_r);
    fl_tok.len     = 7'd1;
    pair_kind      = stl_pkg::K_GE;
    unique case (mode_r)
      stl_pkg::M_IDLE:  fl_tok.kind = stl_pkg::K_END;
      stl_pkg::M_NUM:   begin
        fl_tok.kind  = stl_pkg::K_NUM;
        fl_tok.value = acc_r;
        fl_tok.len   = 7'(run_r);
      end
      stl_pkg::M_STR:   begin
        fl_tok.kind = stl_pkg::K_STR;
        fl_tok.len  = 7'(run_r);
      end
      stl_pkg::M_IDENT: begin
        fl_tok.kind = id_kind;
        fl_tok.len  = 7'(run_r);
      end
      stl_pkg::M_EQ:    begin fl_tok.kind = stl_pkg::K_ASSIGN; pair_kind = stl_pkg::K_EQ;  end
      stl_pkg::M_BANG:  begin fl_tok.kind = stl_pkg::K_UNK;    pair_kind = stl_pkg::K_NEQ; end
      stl_pkg::M_LT:    begin fl_tok.kind = stl_pkg::K_LT;     pair_kind = stl_pkg::K_LE;  end
      stl_pkg::M_GT:    begin fl_tok.kind = stl_pkg::K_GT;     pair_kind = stl_pkg::K_GE;  end
      default:          fl_tok.kind = stl_pkg::K_END;
    endcase
  end

  always_comb begin
    cont      = 1'b0;
    close_str = 1'b0;
    pair      = 1'b0;
    unique case (mode_r)
      stl_pkg::M_NUM:   cont = c_dig && (run_r < RUN_W'(MAX_DIGITS));
      stl_pkg::M_IDENT: cont = (c_alp || c_dig) && (run_r < RUN_W'(MAX_TEXT_LEN));
      stl_pkg::M_STR:   begin
        close_str = (c == stl_pkg::CH_QUOTE);
        cont      = !close_str && (run_r < RUN_W'(MAX_TEXT_LEN));
      end
      stl_pkg::M_EQ, stl_pkg::M_BANG, stl_pkg::M_LT, stl_pkg::M_GT:
        pair = (c == stl_pkg::CH_EQ);
      default: ;
    endcase
    restart = !cont && !close_str && !pair;
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    kwc_nxt   = kwc_r;
    if (take) begin
      if (c_nul) begin
        mode_nxt  = stl_pkg::M_IDLE;
        run_nxt   = '0;
        acc_nxt   = '0;
        start_nxt = '0;
        pos_nxt   = '0;
        kwc_nxt   = '1;
      end else begin
        pos_nxt = pos_wrap;
        if (cont) begin
          run_nxt = run_r + RUN_W'(1);
          if (mode_r == stl_pkg::M_NUM) begin
            acc_nxt = {acc_r[28:0], 3'b000} + {acc_r[30:0], 1'b0} + {28'd0, c[3:0]};
          end
          if (mode_r == stl_pkg::M_IDENT) begin
            kwc_nxt = kwc_r & kw_step;
          end
        end else if (!restart) begin
          mode_nxt = stl_pkg::M_IDLE;
        end else begin
          mode_nxt = st_mode;
          if (!c_ws) begin
            start_nxt = pos_r;
          end
          unique case (st_mode)
            stl_pkg::M_NUM:   begin run_nxt = RUN_W'(1); acc_nxt = {28'd0, c[3:0]}; end
            stl_pkg::M_STR:   begin run_nxt = '0; start_nxt = pos_wrap; end
            stl_pkg::M_IDENT: begin run_nxt = RUN_W'(1); kwc_nxt = kw_first; end
            default: ;
          endcase
        end
      end
    end
  end

  // tokens out
  always_comb begin
    logic          a_emit, b_emit;
    stl_pkg::tok_t sec;
    a_emit    = 1'b0;
    b_emit    = 1'b0;
    sec       = '0;
    sec.start = 16'(pos_r);
    sec.len   = 7'd1;
    sec.last  = 1'b1;
    if (c_nul) begin
      a_emit   = fl_valid;
      b_emit   = 1'b1;
      sec.kind = stl_pkg::K_END;
      sec.len  = 7'd0;
    end else begin
      a_emit = (restart && fl_valid) || close_str;
      if (pair) begin
        b_emit    = 1'b1;
        sec.kind  = pair_kind;
        sec.start = 16'(start_r);
        sec.len   = 7'd2;
      end else begin
        b_emit   = restart && st_emit;
        sec.kind = st_kind;
      end
    end
    push = '0;
    if (take) begin
      if (a_emit) begin
        push.t0      = fl_tok;
        push.t0.last = !b_emit;
        push.t1      = sec;
        push.cnt     = b_emit ? 2'd2 : 2'd1;
      end else begin
        push.t0  = sec;
        push.cnt = b_emit ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= stl_pkg::M_IDLE;
      run_r   <= '0;
      acc_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
      kwc_r   <= '1;
    end else begin
      mode_r  <= mode_nxt;
      run_r   <= run_nxt;
      acc_r   <= acc_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
      kwc_r   <= kwc_nxt;
    end
  end

  a_nul_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (take && c_nul) |=> (pos_r == '0) && (mode_r == stl_pkg::M_IDLE))
    else $error("scanner state not cleared after end of text");

  a_push_max: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd3)
    else $error("more than two tokens from one byte");

  a_nul_end: assert property (@(posedge clk) disable iff (!rst_n)
    (take && c_nul) |->
      ((push.cnt == 2'd1) && (push.t0.kind == stl_pkg::K_END)) ||
      ((push.cnt == 2'd2) && (push.t1.kind == stl_pkg::K_END)))
    else $error("end of text did not close with an End token");

endmodule

`default_nettype wire

>>> sv/stl_tokq.sv
// stl_tokq: back end of the lexer. Token queue taking up to two tokens a
// cycle from the scanner and delivering one beat a cycle on the output
// while deq_stall is low. Depends on stl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stl_tokq (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire stl_pkg::push_t push,
  output logic             room,
  output logic             deq_valid,
  input  wire logic        deq_stall,
  output stl_pkg::tok_t    deq_tok
);

  localparam int QP_W = $clog2(stl_pkg::Q_DEPTH);

  stl_pkg::tok_t   mem_r [stl_pkg::Q_DEPTH];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QP_W:0]   cnt_r, cnt_nxt;
  logic [QP_W-1:0] wr_ptr_1;
  logic            pop;

  assign room      = rst_n && (cnt_r <= (QP_W+1)'(stl_pkg::Q_DEPTH - 2));
  assign deq_valid = rst_n && (cnt_r != '0);
  assign deq_tok   = mem_r[rd_ptr_r];
  assign pop       = deq_valid && !deq_stall;
  assign wr_ptr_1  = wr_ptr_r + QP_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QP_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QP_W'(pop);
    cnt_nxt    = cnt_r + (QP_W+1)'(push.cnt) - (QP_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.t0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_1] <= push.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QP_W+1)'(stl_pkg::Q_DEPTH))
    else $error("token queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.cnt != 2'd0) |-> (cnt_r <= (QP_W+1)'(stl_pkg::Q_DEPTH - 2)))
    else $error("tokens pushed without two free slots");

endmodule

`default_nettype wire

>>> sv/script_token_lexer_top.sv
// script_token_lexer_top: streaming lexer, one source byte per input beat,
// one token per output beat. Instantiates stl_scan and stl_tokq; uses stl_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in_     | into      | in_valid/in_stall  | source_byte
//   out_    | out of    | out_valid/out_stall| token_kind, number_value, start_offset,
//           |           |                    | text_length, last_of_run
//
// Flow: one input beat a cycle unless in_stall is high; the beat that completes a
//   token writes it to the queue, and the head is offered. Each byte gives 0, 1 or 2
//   tokens; the output drains one a cycle unless stalled, bounding the input rate.
// The token queue holds 8 entries; in_stall rises while fewer than two slots
//   are free, since a single byte may push two tokens at once.
// Reset: synchronous, active low; in_stall is held high and
//   out_valid low during reset, and no clearing pass follows.
`timescale 1ns / 1ps
`default_nettype none

module script_token_lexer_top #(
  parameter int MAX_TEXT_LEN = 127,
  parameter int MAX_DIGITS   = 31,
  parameter int MAX_SOURCE   = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // source byte channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_source_byte,
  // token channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_token_kind,
  output logic [31:0]      out_number_value,
  output logic [15:0]      out_start_offset,
  output logic [6:0]       out_text_length,
  output logic             out_last_of_run
);

  stl_pkg::push_t push;
  stl_pkg::tok_t  tok;
  logic           room;
  logic           take;

  // A byte beat is taken only when the queue can swallow the worst case of
  // two tokens, so the scanner itself never has to hold a byte back.
  assign in_stall = !room;
  assign take     = in_valid && room;

  // Front end: classification, run tracking, keyword filtering and number
  // accumulation (shift-and-add by ten, one digit a beat).
  stl_scan #(
    .MAX_TEXT_LEN (MAX_TEXT_LEN),
    .MAX_DIGITS   (MAX_DIGITS),
    .MAX_SOURCE   (MAX_SOURCE)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .src_byte (in_source_byte),
    .push     (push)
  );

  // Back end: token queue. The head entry is the output register, so a
  // stalled token stays put while the scanner keeps taking bytes.
  stl_tokq u_tokq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .deq_valid (out_valid),
    .deq_stall (out_stall),
    .deq_tok   (tok)
  );

  assign out_token_kind   = tok.kind;
  assign out_number_value = tok.value;
  assign out_start_offset = tok.start;
  assign out_text_length  = tok.len;
  assign out_last_of_run  = tok.last;

endmodule

`default_nettype wire

>>> verif/script_token_lexer_top_tb.sv
// script_token_lexer_top_tb: self-checking bench for the script token lexer.
// A scoreboard class predicts the tokens of every accepted source byte and
// checks each token beat in order. Depends on stl_pkg and script_token_lexer_top.
`timescale 1ns / 1ps

module script_token_lexer_top_tb;

  // Scoreboard: its own copy of the scanner state, stepped once per accepted
  // source byte, and the queue of tokens still due from the block.
  class token_scoreboard;
    localparam int MAX_TEXT = 127;
    localparam int MAX_DIG  = 31;
    localparam int MAX_SRC  = 65536;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_USCOR = 8'h5F;

    string kw_names[6] = '{"let", "print", "if", "repeat", "function", "end"};

    stl_pkg::mode_t mode;
    int             run_len;
    bit  [31:0]     acc;
    int             tstart;
    int             pos;
    bit  [5:0]      kw_live;
    stl_pkg::tok_t  due_tokens[$];
    int             errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode    = stl_pkg::M_IDLE;
      run_len = 0;
      acc     = '0;
      tstart  = 0;
      pos     = 0;
      kw_live = '1;
    endfunction

    function int pending();
      return due_tokens.size();
    endfunction

    function bit digit_ch(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit word_ch(logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_USCOR;
    endfunction

    function void push_tok(stl_pkg::kind_t k, bit [31:0] v, int s, int l);
      stl_pkg::tok_t t;
      t.kind  = k;
      t.value = v;
      t.start = s[15:0];
      t.len   = l[6:0];
      t.last  = 1'b0;
      due_tokens.push_back(t);
    endfunction

    // Drop keywords whose character at the current run position differs.
    function void narrow_kw(logic [7:0] c);
      for (int i = 0; i < 6; i++) begin
        if (!(run_len < kw_names[i].len() && kw_names[i][run_len] == c)) kw_live[i] = 1'b0;
      end
    endfunction

    function void flush();
      stl_pkg::kind_t k;
      bit             hit;
      case (mode)
        stl_pkg::M_NUM: push_tok(stl_pkg::K_NUM, acc, tstart, run_len);
        stl_pkg::M_STR: push_tok(stl_pkg::K_STR, '0, tstart, run_len);
        stl_pkg::M_IDENT: begin
          k   = stl_pkg::K_IDENT;
          hit = 1'b0;
          for (int i = 0; i < 6; i++) begin
            if (!hit && kw_live[i] && run_len == kw_names[i].len()) begin
              k   = stl_pkg::kind_t'(int'(stl_pkg::K_LET) + i);
              hit = 1'b1;
            end
          end
          push_tok(k, '0, tstart, run_len);
        end
        stl_pkg::M_EQ:   push_tok(stl_pkg::K_ASSIGN, '0, tstart, 1);
        stl_pkg::M_BANG: push_tok(stl_pkg::K_UNK, '0, tstart, 1);
        stl_pkg::M_LT:   push_tok(stl_pkg::K_LT, '0, tstart, 1);
        stl_pkg::M_GT:   push_tok(stl_pkg::K_GT, '0, tstart, 1);
        default: ;
      endcase
      mode = stl_pkg::M_IDLE;
    endfunction

    function void begin_token(logic [7:0] c);
      stl_pkg::kind_t k;
      mode = stl_pkg::M_IDLE;
      if (c == stl_pkg::CH_SPACE || c == stl_pkg::CH_TAB || c == stl_pkg::CH_CR) return;
      if (digit_ch(c)) begin
        mode    = stl_pkg::M_NUM;
        tstart  = pos;
        run_len = 1;
        acc     = c - CH_ZERO;
        return;
      end
      if (c == stl_pkg::CH_QUOTE) begin
        mode    = stl_pkg::M_STR;
        run_len = 0;
        tstart  = (pos + 1 >= MAX_SRC) ? 0 : pos + 1;
        return;
      end
      if (word_ch(c)) begin
        mode    = stl_pkg::M_IDENT;
        tstart  = pos;
        run_len = 0;
        kw_live = '1;
        narrow_kw(c);
        run_len = 1;
        return;
      end
      tstart = pos;
      case (c)
        stl_pkg::CH_EQ:    begin mode = stl_pkg::M_EQ;   return; end
        stl_pkg::CH_BANG:  begin mode = stl_pkg::M_BANG; return; end
        stl_pkg::CH_LT:    begin mode = stl_pkg::M_LT;   return; end
        stl_pkg::CH_GT:    begin mode = stl_pkg::M_GT;   return; end
        stl_pkg::CH_PLUS:  k = stl_pkg::K_PLUS;
        stl_pkg::CH_MINUS: k = stl_pkg::K_MINUS;
        stl_pkg::CH_STAR:  k = stl_pkg::K_STAR;
        stl_pkg::CH_SLASH: k = stl_pkg::K_SLASH;
        stl_pkg::CH_PCT:   k = stl_pkg::K_PCT;
        stl_pkg::CH_LPAR:  k = stl_pkg::K_LPAR;
        stl_pkg::CH_RPAR:  k = stl_pkg::K_RPAR;
        stl_pkg::CH_COMMA: k = stl_pkg::K_COMMA;
        default:           k = stl_pkg::K_UNK;
      endcase
      push_tok(k, '0, pos, 1);
    endfunction

    // One accepted source byte: queue the tokens it completes.
    function void note_byte(logic [7:0] c);
      int             n_prior;
      stl_pkg::kind_t k;
      n_prior = due_tokens.size();
      if (c == stl_pkg::CH_NUL) begin
        flush();
        push_tok(stl_pkg::K_END, '0, pos, 0);
        due_tokens[due_tokens.size() - 1].last = 1'b1;
        clear();
        return;
      end
      case (mode)
        stl_pkg::M_NUM: begin
          if (digit_ch(c) && run_len < MAX_DIG) begin
            acc = acc * 10 + (c - CH_ZERO);
            run_len++;
          end else begin
            flush();
            begin_token(c);
          end
        end
        stl_pkg::M_IDENT: begin
          if ((word_ch(c) || digit_ch(c)) && run_len < MAX_TEXT) begin
            narrow_kw(c);
            run_len++;
          end else begin
            flush();
            begin_token(c);
          end
        end
        stl_pkg::M_STR: begin
          if (c == stl_pkg::CH_QUOTE) begin
            flush();
          end else if (run_len < MAX_TEXT) begin
            run_len++;
          end else begin
            flush();
            begin_token(c);
          end
        end
        stl_pkg::M_EQ, stl_pkg::M_BANG, stl_pkg::M_LT, stl_pkg::M_GT: begin
          if (c == stl_pkg::CH_EQ) begin
            case (mode)
              stl_pkg::M_EQ:   k = stl_pkg::K_EQ;
              stl_pkg::M_BANG: k = stl_pkg::K_NEQ;
              stl_pkg::M_LT:   k = stl_pkg::K_LE;
              default:         k = stl_pkg::K_GE;
            endcase
            push_tok(k, '0, tstart, 2);
            mode = stl_pkg::M_IDLE;
          end else begin
            flush();
            begin_token(c);
          end
        end
        default: begin_token(c);
      endcase
      if (due_tokens.size() > n_prior) due_tokens[due_tokens.size() - 1].last = 1'b1;
      pos = (pos + 1 >= MAX_SRC) ? 0 : pos + 1;
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_token(logic [4:0] kind, logic [31:0] value, logic [15:0] start,
                              logic [6:0] len, logic last);
      stl_pkg::tok_t e;
      if (due_tokens.size() == 0) begin
        $error("token beat with none due: kind %0d start %0d", kind, start);
        errors++;
        return;
      end
      e = due_tokens.pop_front();
      cmp("token_kind", e.kind, kind);
      cmp("number_value", e.value, value);
      cmp("start_offset", e.start, start);
      cmp("text_length", e.len, len);
      cmp("last_of_run", e.last, last);
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 500000;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_source_byte = 8'h00;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [4:0]  out_token_kind;
  logic [31:0] out_number_value;
  logic [15:0] out_start_offset;
  logic [6:0]  out_text_length;
  logic        out_last_of_run;

  token_scoreboard sb;
  int  cycles     = 0;
  int  bytes_sent = 0;
  int  burst_left = 0;
  bit  idle_on    = 1'b1;

  string digit_set = "0123456789";
  string alpha_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string ops_text[16] = '{"+", "-", "*", "/", "%", "(", ")", ",",
                          "=", "==", "!=", "<", "<=", ">", ">=", "!"};

  script_token_lexer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_source_byte   (in_source_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_number_value (out_number_value),
    .out_start_offset (out_start_offset),
    .out_text_length  (out_text_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a missing token ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver back-pressure, on a repeating pattern: a free-running stretch,
  // then light random stalls, then heavy stalls that fill the token queue.
  always @(negedge clk) begin
    if (cycles % 640 < 160) begin
      out_stall <= 1'b0;
    end else if (cycles % 640 < 400) begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall <= ($urandom_range(0, 4) != 0);
    end
  end

  // Token beats are sampled at the rising edge; out_stall is ours and stable.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_token(out_token_kind, out_number_value, out_start_offset,
                     out_text_length, out_last_of_run);
    end
  end

  // One source beat. Bursts of random length with random gaps between them;
  // with idling off the beats run back to back.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_source_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_rep(input logic [7:0] b, input int n);
    for (int i = 0; i < n; i++) send_byte(b);
  endtask

  // Hold the source side off until every due token has been seen.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One lexeme with random content; mostly well formed, some noise and ends.
  task automatic send_random_lexeme();
    int         pick;
    int         n;
    string      w;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      // numbers, now and then around the digit cap
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(29, 34) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) send_byte(digit_set[$urandom_range(0, 9)]);
    end else if (pick < 38) begin
      if ($urandom_range(0, 1) == 1) begin
        // keywords, their prefixes and extensions
        w = sb.kw_names[$urandom_range(0, 5)];
        case ($urandom_range(0, 3))
          0:       w = w.substr(0, w.len() - 2);
          1:       w = {w, "s"};
          2:       w = {"x", w};
          default: ;
        endcase
        send_text(w);
      end else begin
        n = ($urandom_range(0, 20) == 0) ? $urandom_range(124, 131) : $urandom_range(1, 12);
        send_byte(alpha_set[$urandom_range(0, alpha_set.len() - 1)]);
        for (int i = 1; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) send_byte(digit_set[$urandom_range(0, 9)]);
          else send_byte(alpha_set[$urandom_range(0, alpha_set.len() - 1)]);
        end
      end
    end else if (pick < 50) begin
      // strings: any nonzero byte is text; closing quote usually present
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(124, 130) : $urandom_range(0, 12);
      send_byte(stl_pkg::CH_QUOTE);
      for (int i = 0; i < n; i++) begin
        b = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(1, 255));
        if (b == stl_pkg::CH_QUOTE) b = stl_pkg::CH_PLUS;
        send_byte(b);
      end
      if ($urandom_range(0, 4) != 0) send_byte(stl_pkg::CH_QUOTE);
    end else if (pick < 74) begin
      send_text(ops_text[$urandom_range(0, 15)]);
    end else if (pick < 90) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 3))
          0:       send_byte(stl_pkg::CH_TAB);
          1:       send_byte(stl_pkg::CH_CR);
          default: send_byte(stl_pkg::CH_SPACE);
        endcase
      end
    end else if (pick < 97) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(stl_pkg::CH_NUL);
    end
  endtask

  initial begin
    int rand_start;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // End with nothing pending, straight out of reset
    send_byte(stl_pkg::CH_NUL);
    // keywords and near misses
    send_text("let print if repeat function end lets pri _x9 Zq ");
    // every operator, two-char comparisons, lone bang and unknown bytes
    send_text("+-*/%(),= == != <= >= < > !a");
    send_byte(token_scoreboard::CH_NL);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(stl_pkg::CH_SPACE);
    // number extremes and 32-bit wrap
    send_text("0 4294967295 4294967296 007 ");
    // string with newline and high bytes inside, then an empty string
    send_byte(stl_pkg::CH_QUOTE);
    send_text("a");
    send_byte(token_scoreboard::CH_NL);
    send_byte(8'hFE);
    send_byte(8'h01);
    send_byte(stl_pkg::CH_QUOTE);
    send_byte(stl_pkg::CH_QUOTE);
    send_byte(stl_pkg::CH_QUOTE);
    // digit cap: the 32nd digit starts a new number
    send_rep("9", token_scoreboard::MAX_DIG);
    send_text("12 ");
    // identifier cap
    send_rep("a", token_scoreboard::MAX_TEXT);
    send_text("bc ");
    // capped string, quote taken as the closing one
    send_byte(stl_pkg::CH_QUOTE);
    send_rep("x", token_scoreboard::MAX_TEXT);
    send_byte(stl_pkg::CH_QUOTE);
    // capped string, next byte opens an identifier; end flushes a pending '='
    send_byte(stl_pkg::CH_QUOTE);
    send_rep("y", token_scoreboard::MAX_TEXT);
    send_text("z=");
    send_byte(stl_pkg::CH_NUL);
    // unterminated string flushed by end of text
    send_byte(stl_pkg::CH_QUOTE);
    send_text("open");
    send_byte(stl_pkg::CH_NUL);
    send_text("<");
    send_byte(stl_pkg::CH_NUL);
    send_text("abc");
    send_byte(stl_pkg::CH_NUL);
    drain();

    // Random lexemes, with the odd full drain and idling switched on and off
    idle_on = 1'b1;
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < 150) begin
      send_random_lexeme();
      if ($urandom_range(0, 29) == 0) begin
        drain();
        idle_on = ($urandom_range(0, 2) != 0);
      end
    end
    send_byte(stl_pkg::CH_NUL);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
